/* rtl/core/gb7_pkg.sv */
`default_nettype none
package gb7_pkg;

   localparam int unsigned KERNEL_SIZE = 7;
   localparam int unsigned RADIUS = KERNEL_SIZE / 2;
   localparam int unsigned LINE_ROWS = KERNEL_SIZE - 1;
   localparam int unsigned COEF_BITS = 16;
   localparam int unsigned CHANNELS = 3;
   localparam int unsigned PROD_BITS = 8 + COEF_BITS;
   localparam int unsigned SUM_BITS = PROD_BITS + 3;
   localparam int unsigned MIN_DIM = 7;
   localparam int unsigned MAX_HEIGHT = 4096;
   localparam int unsigned HEIGHT_BITS = 13;
   localparam int unsigned ROW_BITS = 12;
   localparam int unsigned WIDTH_FIELD_BITS = 11;
   localparam int unsigned CSR_ADDR_BITS = 1;
   localparam int unsigned CSR_DATA_BITS = 13;
   localparam int unsigned FIFO_DEPTH = 16;
   localparam int unsigned FIFO_BITS = 4;
   localparam int unsigned CNT_BITS = FIFO_BITS + 1;
   localparam logic [7:0] PIX_MAX = 8'd255;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_addr_type;

   typedef logic [7:0] chan_type;
   typedef chan_type [CHANNELS-1:0] pixel_type;
   typedef pixel_type [KERNEL_SIZE-1:0] column_type;
   typedef pixel_type [LINE_ROWS-1:0] line_word_type;
   typedef logic [COEF_BITS-1:0] coef_type;
   typedef logic [PROD_BITS-1:0] prod_type;
   typedef logic [SUM_BITS-1:0] sum_type;
   typedef sum_type [CHANNELS-1:0] chan_sum_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic       flush;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   typedef struct packed {
      logic       emit;
      logic       last;
      logic [1:0] top;
      logic [1:0] bot;
      logic [1:0] left;
      logic [1:0] right;
   } meta_type;

   // weights by distance from center along each axis
   localparam coef_type COEF_TABLE [0:3][0:3] = '{
      '{16'd3061, 16'd2701, 16'd1856, 16'd994},
      '{16'd2701, 16'd2384, 16'd1638, 16'd877},
      '{16'd1856, 16'd1638, 16'd1126, 16'd603},
      '{16'd994,  16'd877,  16'd603,  16'd323}
   };

   // window index of the tap that output position pos reads, edge clamped
   function automatic logic [2:0] tap_src(input logic [2:0] pos, input logic [1:0] lo,
                                          input logic [1:0] hi);
      logic [3:0] p4;
      logic [2:0] res;
      p4 = {1'b0, pos};
      if (p4 + {2'b00, lo} < 4'd3) begin
         res = 3'd3 + {1'b0, lo};
      end else if (p4 > 4'd3 + {2'b00, hi}) begin
         res = 3'd3 - {1'b0, hi};
      end else begin
         res = 3'd6 - pos;
      end
      return res;
   endfunction

   function automatic coef_type coef_at(input logic [2:0] a, input logic [2:0] b);
      logic [2:0] u;
      logic [2:0] v;
      u = (a >= 3'd3) ? a - 3'd3 : 3'd3 - a;
      v = (b >= 3'd3) ? b - 3'd3 : 3'd3 - b;
      return COEF_TABLE[u[1:0]][v[1:0]];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/gb7_col_cell.sv */
`default_nettype none
module gb7_col_cell (
   input  logic                clock,
   input  logic                shift,
   input  gb7_pkg::column_type col_in,
   output gb7_pkg::column_type col_out
);
   import gb7_pkg::*;

   column_type taps_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         taps_ff <= col_in;
      end
   end

   assign col_out = taps_ff;

endmodule
`default_nettype wire

/* rtl/core/gb7_row_mac.sv */
`default_nettype none
module gb7_row_mac (
   input  logic                  clock,
   input  logic [2:0]            row_idx,
   input  gb7_pkg::column_type   taps,
   input  logic [1:0]            left,
   input  logic [1:0]            right,
   output gb7_pkg::chan_sum_type row_sum
);
   import gb7_pkg::*;

   prod_type     prod_ff [KERNEL_SIZE][CHANNELS];
   chan_sum_type sum_in;
   chan_sum_type sum_ff;

   // column clamp and weight
   always_ff @(posedge clock) begin
      for (int b = 0; b < KERNEL_SIZE; b++) begin
         for (int ch = 0; ch < CHANNELS; ch++) begin
            prod_ff[b][ch] <= PROD_BITS'(taps[tap_src(3'(b), left, right)][ch])
                              * PROD_BITS'(coef_at(row_idx, 3'(b)));
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sum_in[ch] = '0;
         for (int b = 0; b < KERNEL_SIZE; b++) begin
            sum_in[ch] = sum_in[ch] + SUM_BITS'(prod_ff[b][ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign row_sum = sum_ff;

endmodule
`default_nettype wire

/* rtl/core/gaussian_blur_7x7_rgb.sv */
`default_nettype none
// 7x7 Gaussian blur (sigma 2) on an RGB raster stream with edge clamping. One item per clock
// is taken on the req channel while req_ready is high; the blurred pixel for position p comes
// out with the item that lands at p + 3*width + 3, so the host ends each frame with 3*width + 3
// flush items, and frame_end marks the last pixel. The rate is set by the single line memory
// word (six rows per column address) and a 16-entry result queue that stalls req only when rsp
// is held off. Writing image_width or image_height restarts the frame; write them only while
// idle.
module gaussian_blur_7x7_rgb #(
   parameter int unsigned MAX_WIDTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gb7_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gb7_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [gb7_pkg::CSR_ADDR_BITS-1:0]    csr_addr,
   input  logic [gb7_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import gb7_pkg::*;

   localparam int unsigned COL_BITS = $clog2(MAX_WIDTH);
   localparam int unsigned WID_BITS = $clog2(MAX_WIDTH + 1);
   localparam int unsigned WIDTH_RESET = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
   localparam int unsigned SCALED_BITS = SUM_BITS - COEF_BITS;

   logic [WID_BITS-1:0]    width_ff;
   logic [WID_BITS-1:0]    width_in;
   logic [HEIGHT_BITS-1:0] height_ff;
   logic [HEIGHT_BITS-1:0] height_in;
   logic [31:0]            wcand;

   logic [COL_BITS-1:0]    in_col_ff, in_col_in;
   logic [1:0]             in_row_ff, in_row_in;
   logic                   started_ff, started_in;
   logic [COL_BITS-1:0]    out_c_ff, out_c_in;
   logic [ROW_BITS-1:0]    out_r_ff, out_r_in;

   logic                   accept;
   logic                   emit0;
   logic                   last0;
   logic                   col_last;
   logic                   out_col_last;
   logic                   out_row_last;
   logic [HEIGHT_BITS-1:0] bot_diff;
   logic [WID_BITS-1:0]    right_diff;
   meta_type               meta0;
   pixel_type              pix0;

   logic                   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   meta_type               meta1_ff, meta2_ff, meta3_ff, meta4_ff, meta5_ff, meta6_ff;
   pixel_type              pix1_ff;
   logic [COL_BITS-1:0]    col1_ff;
   line_word_type          rd_ff;
   line_word_type          line_mem [MAX_WIDTH];

   column_type             col_new;
   column_type             cell_out [KERNEL_SIZE];
   column_type             sel_in [KERNEL_SIZE];
   column_type             sel_ff [KERNEL_SIZE];
   chan_sum_type           row_sum [KERNEL_SIZE];
   chan_sum_type           total;
   logic [SCALED_BITS-1:0] scaled;
   pixel_type              pix6_in;
   pixel_type              pix6_ff;

   rsp_type                fifo_mem [FIFO_DEPTH];
   rsp_type                push_data;
   logic [FIFO_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]    fifo_cnt_ff;
   logic [CNT_BITS-1:0]    cnt_ff;
   logic                   push;
   logic                   pop;

   // configuration
   always_comb begin
      wcand = 32'(csr_wdata[WIDTH_FIELD_BITS-1:0]);
      if (wcand < MIN_DIM) begin
         width_in = WID_BITS'(MIN_DIM);
      end else if (wcand > MAX_WIDTH) begin
         width_in = WID_BITS'(MAX_WIDTH);
      end else begin
         width_in = WID_BITS'(wcand);
      end
      if (csr_wdata < HEIGHT_BITS'(MIN_DIM)) begin
         height_in = HEIGHT_BITS'(MIN_DIM);
      end else if (csr_wdata > HEIGHT_BITS'(MAX_HEIGHT)) begin
         height_in = HEIGHT_BITS'(MAX_HEIGHT);
      end else begin
         height_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_BITS'(WIDTH_RESET);
         height_ff <= HEIGHT_BITS'(480);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:  width_ff  <= width_in;
            CSR_IMAGE_HEIGHT: height_ff <= height_in;
         endcase
      end
   end

   // position tracking
   assign req_ready    = cnt_ff < CNT_BITS'(FIFO_DEPTH);
   assign accept       = req_valid && req_ready;
   assign emit0        = started_ff || (in_row_ff == 2'd3 && in_col_ff == COL_BITS'(3));
   assign col_last     = WID_BITS'(in_col_ff) == width_ff - WID_BITS'(1);
   assign out_col_last = WID_BITS'(out_c_ff) == width_ff - WID_BITS'(1);
   assign out_row_last = HEIGHT_BITS'(out_r_ff) == height_ff - HEIGHT_BITS'(1);
   assign last0        = emit0 && out_col_last && out_row_last;
   assign bot_diff     = height_ff - HEIGHT_BITS'(1) - HEIGHT_BITS'(out_r_ff);
   assign right_diff   = width_ff - WID_BITS'(1) - WID_BITS'(out_c_ff);

   always_comb begin
      meta0.emit  = emit0;
      meta0.last  = last0;
      meta0.top   = (out_r_ff >= ROW_BITS'(3)) ? 2'd3 : out_r_ff[1:0];
      meta0.bot   = (bot_diff >= HEIGHT_BITS'(3)) ? 2'd3 : bot_diff[1:0];
      meta0.left  = (out_c_ff >= COL_BITS'(3)) ? 2'd3 : out_c_ff[1:0];
      meta0.right = (right_diff >= WID_BITS'(3)) ? 2'd3 : right_diff[1:0];
      pix0 = req_data.flush ? '0
           : pixel_type'({req_data.blue_in, req_data.green_in, req_data.red_in});
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      started_in = started_ff;
      out_c_in   = out_c_ff;
      out_r_in   = out_r_ff;
      if (csr_we || (accept && last0)) begin
         in_col_in  = '0;
         in_row_in  = '0;
         started_in = 1'b0;
         out_c_in   = '0;
         out_r_in   = '0;
      end else if (accept) begin
         if (col_last) begin
            in_col_in = '0;
            if (in_row_ff != 2'd3) begin
               in_row_in = in_row_ff + 2'd1;
            end
         end else begin
            in_col_in = in_col_ff + COL_BITS'(1);
         end
         started_in = emit0;
         if (emit0) begin
            if (out_col_last) begin
               out_c_in = '0;
               out_r_in = out_r_ff + ROW_BITS'(1);
            end else begin
               out_c_in = out_c_ff + COL_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         started_ff <= 1'b0;
         out_c_ff   <= '0;
         out_r_ff   <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         started_ff <= started_in;
         out_c_ff   <= out_c_in;
         out_r_ff   <= out_r_in;
      end
   end

   // line memory: each word holds the six rows above at this column
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[in_col_ff];
      end
      if (v1_ff) begin
         line_mem[col1_ff] <= {rd_ff[LINE_ROWS-2:0], pix1_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff  <= pix0;
         col1_ff  <= in_col_ff;
         meta1_ff <= meta0;
      end
      meta2_ff <= meta1_ff;
      meta3_ff <= meta2_ff;
      meta4_ff <= meta3_ff;
      meta5_ff <= meta4_ff;
      meta6_ff <= meta5_ff;
      sel_ff   <= sel_in;
      pix6_ff  <= pix6_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   // window: chain of column cells, newest column in cell 0
   assign col_new = column_type'({rd_ff, pix1_ff});

   for (genvar j = 0; j < KERNEL_SIZE; j++) begin : g_cell
      if (j == 0) begin : g_head
         gb7_col_cell u_cell (
            .clock   (clock),
            .shift   (v1_ff),
            .col_in  (col_new),
            .col_out (cell_out[j])
         );
      end else begin : g_tail
         gb7_col_cell u_cell (
            .clock   (clock),
            .shift   (v1_ff),
            .col_in  (cell_out[j-1]),
            .col_out (cell_out[j])
         );
      end
   end

   // row clamp
   always_comb begin
      for (int a = 0; a < KERNEL_SIZE; a++) begin
         for (int j = 0; j < KERNEL_SIZE; j++) begin
            sel_in[a][j] = cell_out[j][tap_src(3'(a), meta2_ff.top, meta2_ff.bot)];
         end
      end
   end

   for (genvar a = 0; a < KERNEL_SIZE; a++) begin : g_row
      gb7_row_mac u_mac (
         .clock   (clock),
         .row_idx (3'(a)),
         .taps    (sel_ff[a]),
         .left    (meta3_ff.left),
         .right   (meta3_ff.right),
         .row_sum (row_sum[a])
      );
   end

   always_comb begin
      scaled = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         total[ch] = '0;
         for (int a = 0; a < KERNEL_SIZE; a++) begin
            total[ch] = total[ch] + row_sum[a][ch];
         end
         scaled = total[ch][SUM_BITS-1:COEF_BITS];
         pix6_in[ch] = (scaled > SCALED_BITS'(PIX_MAX)) ? PIX_MAX : scaled[7:0];
      end
   end

   // result queue
   assign push      = v6_ff && meta6_ff.emit;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = fifo_cnt_ff != '0;
   assign rsp_data  = fifo_mem[rd_ptr_ff];

   always_comb begin
      push_data.red_out   = pix6_ff[0];
      push_data.green_out = pix6_ff[1];
      push_data.blue_out  = pix6_ff[2];
      push_data.frame_end = meta6_ff.last;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         cnt_ff      <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_BITS'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + CNT_BITS'(push) - CNT_BITS'(pop);
         cnt_ff      <= cnt_ff + CNT_BITS'(accept && emit0) - CNT_BITS'(pop);
      end
   end

`ifndef SYNTHESIS
   a_queue_within_credit: assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= cnt_ff)
      else $error("result queue holds more than the transfers in flight");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_cnt_ff < CNT_BITS'(FIFO_DEPTH)) || pop)
      else $error("result queue overflow");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last0 && !csr_we) |=> (out_r_ff == '0 && out_c_ff == '0 && !started_ff))
      else $error("position not cleared after last pixel");
`endif

endmodule
`default_nettype wire
